// ===== design/im2col_address_generator_core_defines.svh =====
// Assertion helpers for the im2col address generator.
`ifndef IM2COL_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define IM2COL_ADDRESS_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("im2col address generator: assertion failed");
`define I2CAG_ASSERT_NEVER(lbl, cond) `I2CAG_ASSERT(lbl, !(cond))
`else
`define I2CAG_ASSERT(lbl, prop)
`define I2CAG_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== design/i2cag_pkg.sv =====
`default_nettype none

package i2cag_pkg;

  // position counters for channel, output row and output column
  localparam int CountWidth = 12;
  // kernel tap counters
  localparam int TapWidth   = 8;
  localparam int TapLimW    = TapWidth + 1;
  // width of the count-type configuration registers
  localparam int CfgCountW  = 13;
  localparam int LimW       = CountWidth + 1;
  localparam int CmpW       = (CfgCountW > LimW) ? CfgCountW : LimW;
  localparam int AddrW      = 32;
  localparam int PaddrW     = 5;

  // products and source coordinates
  localparam int DstProdW   = CountWidth + TapWidth;
  localparam int TapProdW   = 2 * TapWidth;
  localparam int PosW       = ((DstProdW > TapProdW) ? DstProdW : TapProdW) + 2;
  localparam int ChProdW    = CountWidth + CfgCountW;
  localparam int RowTermW   = ((ChProdW > PosW) ? ChProdW : PosW) + 1;

  typedef enum logic [2:0] {
    RegChannels  = 3'd0,
    RegSrcHeight = 3'd1,
    RegSrcWidth  = 3'd2,
    RegDstHeight = 3'd3,
    RegDstWidth  = 3'd4,
    RegWindowY   = 3'd5,
    RegWindowX   = 3'd6,
    RegSrcBase   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CfgCountW-1:0] channels;
    logic [CfgCountW-1:0] dst_height;
    logic [CfgCountW-1:0] dst_width;
    logic [TapWidth-1:0]  kernel_y;
    logic [TapWidth-1:0]  kernel_x;
  } seq_cfg_t;

  typedef struct packed {
    logic [CountWidth-1:0] ch;
    logic [TapWidth-1:0]   tap_row;
    logic [TapWidth-1:0]   tap_col;
    logic [CountWidth-1:0] out_row;
    logic [CountWidth-1:0] out_col;
    logic                  row_end;
    logic                  last;
  } pos_t;

  // zero acts as one, anything past 2^CountWidth saturates
  function automatic logic [LimW-1:0] lim_count(logic [CfgCountW-1:0] v);
    logic [CmpW-1:0] ext;
    logic [CmpW-1:0] top;
    ext = CmpW'(v);
    top = CmpW'(1) << CountWidth;
    if (v == '0) begin
      return LimW'(1);
    end else if (ext > top) begin
      return top[LimW-1:0];
    end else begin
      return ext[LimW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/i2cag_seq.sv =====
`default_nettype none

module i2cag_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic               restart_i,
  input  wire i2cag_pkg::seq_cfg_t cfg_i,
  output i2cag_pkg::pos_t         pos_o
);

  logic [i2cag_pkg::CountWidth-1:0] ch_q, ch_d, out_row_q, out_row_d, out_col_q, out_col_d;
  logic [i2cag_pkg::TapWidth-1:0]   tap_row_q, tap_row_d, tap_col_q, tap_col_d;
  logic [i2cag_pkg::CountWidth-1:0] cur_ch, cur_out_row, cur_out_col;
  logic [i2cag_pkg::TapWidth-1:0]   cur_tap_row, cur_tap_col;
  logic [i2cag_pkg::LimW-1:0]       lim_c, lim_dy, lim_dx;
  logic [i2cag_pkg::TapWidth-1:0]   lim_ky, lim_kx;
  logic e_c, e_ky, e_kx, e_dy, e_dx;

  // restart replaces the stored position by the first element
  assign cur_ch      = restart_i ? '0 : ch_q;
  assign cur_tap_row = restart_i ? '0 : tap_row_q;
  assign cur_tap_col = restart_i ? '0 : tap_col_q;
  assign cur_out_row = restart_i ? '0 : out_row_q;
  assign cur_out_col = restart_i ? '0 : out_col_q;

  assign lim_c  = i2cag_pkg::lim_count(cfg_i.channels);
  assign lim_dy = i2cag_pkg::lim_count(cfg_i.dst_height);
  assign lim_dx = i2cag_pkg::lim_count(cfg_i.dst_width);
  assign lim_ky = (cfg_i.kernel_y == '0) ? i2cag_pkg::TapWidth'(1) : cfg_i.kernel_y;
  assign lim_kx = (cfg_i.kernel_x == '0) ? i2cag_pkg::TapWidth'(1) : cfg_i.kernel_x;

  // a counter at or past its last value counts as at the end
  assign e_c  = (i2cag_pkg::LimW'(cur_ch) + i2cag_pkg::LimW'(1)) >= lim_c;
  assign e_dy = (i2cag_pkg::LimW'(cur_out_row) + i2cag_pkg::LimW'(1)) >= lim_dy;
  assign e_dx = (i2cag_pkg::LimW'(cur_out_col) + i2cag_pkg::LimW'(1)) >= lim_dx;
  assign e_ky = (i2cag_pkg::TapLimW'(cur_tap_row) + i2cag_pkg::TapLimW'(1))
                >= i2cag_pkg::TapLimW'(lim_ky);
  assign e_kx = (i2cag_pkg::TapLimW'(cur_tap_col) + i2cag_pkg::TapLimW'(1))
                >= i2cag_pkg::TapLimW'(lim_kx);

  always_comb begin
    ch_d      = cur_ch;
    tap_row_d = cur_tap_row;
    tap_col_d = cur_tap_col;
    out_row_d = cur_out_row;
    out_col_d = cur_out_col;
    // output column fastest, channel slowest
    if (!e_dx) begin
      out_col_d = cur_out_col + 1'b1;
    end else begin
      out_col_d = '0;
      if (!e_dy) begin
        out_row_d = cur_out_row + 1'b1;
      end else begin
        out_row_d = '0;
        if (!e_kx) begin
          tap_col_d = cur_tap_col + 1'b1;
        end else begin
          tap_col_d = '0;
          if (!e_ky) begin
            tap_row_d = cur_tap_row + 1'b1;
          end else begin
            tap_row_d = '0;
            ch_d      = e_c ? '0 : cur_ch + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q      <= '0;
      tap_row_q <= '0;
      tap_col_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (advance_i) begin
      ch_q      <= ch_d;
      tap_row_q <= tap_row_d;
      tap_col_q <= tap_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  assign pos_o.ch      = cur_ch;
  assign pos_o.tap_row = cur_tap_row;
  assign pos_o.tap_col = cur_tap_col;
  assign pos_o.out_row = cur_out_row;
  assign pos_o.out_col = cur_out_col;
  assign pos_o.row_end = e_dx;
  assign pos_o.last    = e_dx && e_dy && e_kx && e_ky && e_c;

endmodule

`default_nettype wire

// ===== design/im2col_address_generator_core.sv =====
// Channel  | Direction | Handshake               | Payload
// in       | to core   | in_valid_i / in_stall_o | restart_i
// out      | from core | out_valid_o / out_stall_i | source_address_o, is_padding_o,
//          |           |                         | row_end_o, last_o
// cfg      | to core   | psel/penable/pready     | paddr, pwdata, prdata
//
// One item per cycle while out_stall_i does not hold the output; items pass the stages in order.
// The five-stage path is: position counters, coordinate multiplies, source
// coordinates and bounds check, row-address multiply, final add into the
// output register. Reset clears the position counters and the stage valids and
// loads the register defaults. A stalled output stops only the stages behind
// it that are full; empty stages keep taking items.
`default_nettype none
`include "im2col_address_generator_core_defines.svh"

module im2col_address_generator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         restart_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [31:0]                       source_address_o,
  output logic                              is_padding_o,
  output logic                              row_end_o,
  output logic                              last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [i2cag_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CW = i2cag_pkg::CfgCountW;

  logic [CW-1:0] channels_q, src_height_q, src_width_q, dst_height_q, dst_width_q;
  logic [31:0]   window_y_q, window_x_q, source_base_q;
  logic          cfg_wr;
  i2cag_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = i2cag_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q    <= CW'(1);
      src_height_q  <= CW'(1);
      src_width_q   <= CW'(1);
      dst_height_q  <= CW'(1);
      dst_width_q   <= CW'(1);
      window_y_q    <= 32'h0101_0100;
      window_x_q    <= 32'h0101_0100;
      source_base_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        i2cag_pkg::RegChannels:  channels_q    <= pwdata[CW-1:0];
        i2cag_pkg::RegSrcHeight: src_height_q  <= pwdata[CW-1:0];
        i2cag_pkg::RegSrcWidth:  src_width_q   <= pwdata[CW-1:0];
        i2cag_pkg::RegDstHeight: dst_height_q  <= pwdata[CW-1:0];
        i2cag_pkg::RegDstWidth:  dst_width_q   <= pwdata[CW-1:0];
        i2cag_pkg::RegWindowY:   window_y_q    <= pwdata;
        i2cag_pkg::RegWindowX:   window_x_q    <= pwdata;
        i2cag_pkg::RegSrcBase:   source_base_q <= pwdata;
        default:                 source_base_q <= source_base_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2cag_pkg::RegChannels:  prdata = 32'(channels_q);
      i2cag_pkg::RegSrcHeight: prdata = 32'(src_height_q);
      i2cag_pkg::RegSrcWidth:  prdata = 32'(src_width_q);
      i2cag_pkg::RegDstHeight: prdata = 32'(dst_height_q);
      i2cag_pkg::RegDstWidth:  prdata = 32'(dst_width_q);
      i2cag_pkg::RegWindowY:   prdata = window_y_q;
      i2cag_pkg::RegWindowX:   prdata = window_x_q;
      i2cag_pkg::RegSrcBase:   prdata = source_base_q;
      default:                 prdata = '0;
    endcase
  end

  // window fields
  logic [7:0] stride_y, dil_y, pad_y, stride_x, dil_x, pad_x;
  assign stride_y = window_y_q[23:16];
  assign dil_y    = window_y_q[15:8];
  assign pad_y    = window_y_q[7:0];
  assign stride_x = window_x_q[23:16];
  assign dil_x    = window_x_q[15:8];
  assign pad_x    = window_x_q[7:0];

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o, accept;

  assign rdy_o  = !out_valid_q || !out_stall_i;
  assign rdy4   = !v4_q || rdy_o;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = in_valid_i && rdy1;
  assign in_stall_o  = !rdy1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q        <= accept;
      if (rdy2)  v2_q        <= v1_q;
      if (rdy3)  v3_q        <= v2_q;
      if (rdy4)  v4_q        <= v3_q;
      if (rdy_o) out_valid_q <= v4_q;
    end
  end

  // stage 1: position of the element
  i2cag_pkg::seq_cfg_t seq_cfg;
  i2cag_pkg::pos_t     pos, s1_q;

  assign seq_cfg.channels   = channels_q;
  assign seq_cfg.dst_height = dst_height_q;
  assign seq_cfg.dst_width  = dst_width_q;
  assign seq_cfg.kernel_y   = window_y_q[31:24];
  assign seq_cfg.kernel_x   = window_x_q[31:24];

  i2cag_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .restart_i (restart_i),
    .cfg_i     (seq_cfg),
    .pos_o     (pos)
  );

  // stage 2: coordinate products
  logic [i2cag_pkg::DstProdW-1:0] py_dst_q, px_dst_q;
  logic [i2cag_pkg::TapProdW-1:0] py_tap_q, px_tap_q;
  logic [i2cag_pkg::ChProdW-1:0]  ch_rows_q;
  logic                           s2_row_end_q, s2_last_q;

  // stage 3: source coordinates, bounds and partial address
  logic [i2cag_pkg::PosW-1:0]     sy, sx;
  logic                           pad;
  logic [i2cag_pkg::RowTermW-1:0] row_term_q;
  logic [31:0]                    base_sx_q;
  logic                           s3_pad_q, s3_row_end_q, s3_last_q;

  // stage 4: row address
  logic [31:0] row_addr_q, s4_base_sx_q;
  logic        s4_pad_q, s4_row_end_q, s4_last_q;

  // sign bit set means the tap lies before the image start
  assign sy = i2cag_pkg::PosW'(py_dst_q) + i2cag_pkg::PosW'(py_tap_q)
              - i2cag_pkg::PosW'(pad_y);
  assign sx = i2cag_pkg::PosW'(px_dst_q) + i2cag_pkg::PosW'(px_tap_q)
              - i2cag_pkg::PosW'(pad_x);
  assign pad = sy[i2cag_pkg::PosW-1] || sx[i2cag_pkg::PosW-1]
            || (sy[i2cag_pkg::PosW-2:0] >= (i2cag_pkg::PosW-1)'(src_height_q))
            || (sx[i2cag_pkg::PosW-2:0] >= (i2cag_pkg::PosW-1)'(src_width_q));

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= pos;
    if (rdy2) begin
      py_dst_q     <= i2cag_pkg::DstProdW'(s1_q.out_row) * i2cag_pkg::DstProdW'(stride_y);
      py_tap_q     <= i2cag_pkg::TapProdW'(s1_q.tap_row) * i2cag_pkg::TapProdW'(dil_y);
      px_dst_q     <= i2cag_pkg::DstProdW'(s1_q.out_col) * i2cag_pkg::DstProdW'(stride_x);
      px_tap_q     <= i2cag_pkg::TapProdW'(s1_q.tap_col) * i2cag_pkg::TapProdW'(dil_x);
      ch_rows_q    <= i2cag_pkg::ChProdW'(s1_q.ch) * i2cag_pkg::ChProdW'(src_height_q);
      s2_row_end_q <= s1_q.row_end;
      s2_last_q    <= s1_q.last;
    end
    if (rdy3) begin
      row_term_q   <= i2cag_pkg::RowTermW'(ch_rows_q) + i2cag_pkg::RowTermW'(sy);
      base_sx_q    <= source_base_q + 32'(sx);
      s3_pad_q     <= pad;
      s3_row_end_q <= s2_row_end_q;
      s3_last_q    <= s2_last_q;
    end
    if (rdy4) begin
      row_addr_q   <= 32'(row_term_q * (i2cag_pkg::RowTermW + CW)'(src_width_q));
      s4_base_sx_q <= base_sx_q;
      s4_pad_q     <= s3_pad_q;
      s4_row_end_q <= s3_row_end_q;
      s4_last_q    <= s3_last_q;
    end
    if (rdy_o) begin
      source_address_o <= s4_pad_q ? '0 : row_addr_q + s4_base_sx_q;
      is_padding_o     <= s4_pad_q;
      row_end_o        <= s4_row_end_q;
      last_o           <= s4_last_q;
    end
  end

  `I2CAG_ASSERT(a_last_ends_row, (out_valid_o && last_o) |-> row_end_o)
  `I2CAG_ASSERT(a_pad_zero_addr, (out_valid_o && is_padding_o) |-> (source_address_o == '0))
  // the counters sit above row_end and last
  `I2CAG_ASSERT(a_restart_first, (accept && restart_i) |=> ((s1_q >> 2) == '0))
  `I2CAG_ASSERT_NEVER(a_stall_no_room, in_stall_o && !v1_q)

endmodule

`default_nettype wire
